FILE: design/linear_search_key_value_table_core_macros.svh
// assertion macros for the key/value table core
`ifndef LINEAR_SEARCH_KEY_VALUE_TABLE_CORE_MACROS_SVH
`define LINEAR_SEARCH_KEY_VALUE_TABLE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LSKVT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LSKVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LSKVT_ASSERT_SAME(lbl, ante, cons, msg)
`define LSKVT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/lskvt_pkg.sv
// shared constants and types for the key/value table core
package lskvt_pkg;

  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] FUNC_FIND     = 3'd0;
  localparam logic [2:0] FUNC_INSERT   = 3'd1;
  localparam logic [2:0] FUNC_GET      = 3'd2;
  localparam logic [2:0] FUNC_ASSIGN   = 3'd3;
  localparam logic [2:0] FUNC_ERASE    = 3'd4;
  localparam logic [2:0] FUNC_READ_POS = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic start;
    logic scan;
    logic shift;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic       hit;
    logic       miss;
    logic       shift_done;
    logic       out_free;
    logic [2:0] func;
  } stat_t;

endpackage

FILE: design/lskvt_if.sv
// request and response channel interfaces
interface lskvt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] req_key;
  logic [31:0] req_value;
  logic [5:0]  position;
  modport source (output valid, func, req_key, req_value, position, input ready);
  modport sink (input valid, func, req_key, req_value, position, output ready);
endinterface

interface lskvt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic        inserted;
  logic [31:0] out_key;
  logic [31:0] out_value;
  logic [5:0]  entry_position;
  logic [6:0]  entries_used;
  modport source (output valid, status, found, inserted, out_key, out_value,
                  entry_position, entries_used, input ready);
  modport sink (input valid, status, found, inserted, out_key, out_value,
                entry_position, entries_used, output ready);
endinterface

FILE: design/linear_search_key_value_table_core.sv
// after a request transfer, search scans entries in order until a hit or the end;
// erase then moves each later entry down one place; read_at_position reads one entry;
// an unused code goes straight to the result; each then waits for the previous result
// one operation at a time; next request taken the cycle after the result is registered
// longest operation: erase of the first of 64 entries (scan then shift)
// reset clears the entry count and the handshake state; table memories are not cleared
`include "linear_search_key_value_table_core_macros.svh"
module linear_search_key_value_table_core (
  input logic         clk,
  input logic         rst,
  lskvt_req_if.sink   req,
  lskvt_rsp_if.source rsp
);
  import lskvt_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  ctrl_ready;

  assign req.ready = ctrl_ready;

  lskvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_func  (req.func),
    .in_ready (ctrl_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lskvt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .func      (req.func),
    .req_key   (req.req_key),
    .req_value (req.req_value),
    .position  (req.position),
    .cmd       (cmd),
    .st        (st),
    .rsp       (rsp)
  );

  `LSKVT_ASSERT_NEXT(a_one_at_a_time, req.valid && req.ready, !req.ready,
                     "request taken while busy")
  `LSKVT_ASSERT_SAME(a_used_bound, rsp.valid, rsp.entries_used <= 7'(TABLE_DEPTH),
                     "count overflow")
  `LSKVT_ASSERT_SAME(a_ins_ok, rsp.valid && rsp.inserted,
                     rsp.status == ST_OK && !rsp.found, "bad insert flags")

endmodule

FILE: design/lskvt_ctrl.sv
// controller state machine for the key/value table core
module lskvt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [2:0]       in_func,
  output logic             in_ready,
  input  lskvt_pkg::stat_t st,
  output lskvt_pkg::cmd_t  cmd
);
  import lskvt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SEARCH  = 5'b00010,
    S_SHIFT   = 5'b00100,
    S_WAIT_RD = 5'b01000,
    S_FINISH  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          if (in_func == FUNC_READ_POS) begin
            state_next = S_WAIT_RD;
          end else if (in_func <= FUNC_ERASE) begin
            state_next = S_SEARCH;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SEARCH: begin
        cmd.scan = 1'b1;
        if (st.hit) begin
          state_next = (st.func == FUNC_ERASE) ? S_SHIFT : S_FINISH;
        end else if (st.miss) begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (st.shift_done) begin
          state_next = S_FINISH;
        end
      end
      S_WAIT_RD: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/lskvt_datapath.sv
// table memories, scan and shift pointers, result register
module lskvt_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [2:0]                       func,
  input  logic [lskvt_pkg::KEY_BITS-1:0]   req_key,
  input  logic [lskvt_pkg::VALUE_BITS-1:0] req_value,
  input  logic [lskvt_pkg::IDX_BITS-1:0]   position,
  input  lskvt_pkg::cmd_t                  cmd,
  output lskvt_pkg::stat_t                 st,
  lskvt_rsp_if.source                      rsp
);
  import lskvt_pkg::*;

  logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;

  logic [2:0]            r_func;
  logic [KEY_BITS-1:0]   r_key;
  logic [VALUE_BITS-1:0] r_value;
  logic [IDX_BITS-1:0]   r_pos;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   idx;
  logic                  pend;
  logic [IDX_BITS-1:0]   pend_idx;
  logic                  hit_reg;
  logic [IDX_BITS-1:0]   hit_idx;
  logic [VALUE_BITS-1:0] hit_val;

  logic                  out_valid;
  logic [1:0]            o_status;
  logic                  o_found;
  logic                  o_ins;
  logic [KEY_BITS-1:0]   o_key;
  logic [VALUE_BITS-1:0] o_value;
  logic [IDX_BITS-1:0]   o_pos;
  logic [CNT_BITS-1:0]   o_used;

  logic [CNT_BITS-1:0]   idx_inc;
  logic                  hit;
  logic [IDX_BITS-1:0]   rd_addr;

  logic [1:0]            res_status;
  logic                  res_found;
  logic                  res_ins;
  logic [KEY_BITS-1:0]   res_key;
  logic [VALUE_BITS-1:0] res_value;
  logic [IDX_BITS-1:0]   res_pos;
  logic [CNT_BITS-1:0]   res_used;
  logic                  fin_we;
  logic [IDX_BITS-1:0]   fin_addr;
  logic [KEY_BITS-1:0]   fin_key;
  logic [VALUE_BITS-1:0] fin_value;

  logic                  we;
  logic [IDX_BITS-1:0]   wa;
  logic [KEY_BITS-1:0]   wk;
  logic [VALUE_BITS-1:0] wv;

  assign idx_inc = idx + CNT_BITS'(1);
  assign hit     = pend && (key_rd == r_key);

  // shift reads one ahead of the destination; otherwise scan pointer or position
  always_comb begin
    if (cmd.shift) begin
      rd_addr = idx_inc[IDX_BITS-1:0];
    end else if (r_func == FUNC_READ_POS) begin
      rd_addr = r_pos;
    end else begin
      rd_addr = idx[IDX_BITS-1:0];
    end
  end

  assign st.hit        = hit;
  assign st.miss       = !pend && (idx >= count);
  assign st.shift_done = !pend && (idx_inc >= count);
  assign st.out_free   = !out_valid || rsp.ready;
  assign st.func       = r_func;

  always_ff @(posedge clk) begin
    key_rd <= key_mem[rd_addr];
    val_rd <= val_mem[rd_addr];
    if (we) begin
      key_mem[wa] <= wk;
      val_mem[wa] <= wv;
    end
  end

  // result of the finished operation, with the table write it implies
  always_comb begin
    res_status = ST_NOTFOUND;
    res_found  = 1'b0;
    res_ins    = 1'b0;
    res_key    = '0;
    res_value  = '0;
    res_pos    = '0;
    res_used   = count;
    fin_we     = 1'b0;
    fin_addr   = hit_idx;
    fin_key    = r_key;
    fin_value  = r_value;
    case (r_func)
      FUNC_FIND, FUNC_INSERT, FUNC_GET, FUNC_ASSIGN, FUNC_ERASE: begin
        if (hit_reg) begin
          res_status = ST_OK;
          res_found  = 1'b1;
          res_key    = r_key;
          res_pos    = hit_idx;
          res_value  = hit_val;
          if (r_func == FUNC_ASSIGN) begin
            res_value = r_value;
            fin_we    = 1'b1;
          end
          if (r_func == FUNC_ERASE) begin
            res_used = count - CNT_BITS'(1);
          end
        end else if (r_func != FUNC_FIND && r_func != FUNC_ERASE) begin
          res_key = r_key;
          if (count >= CNT_BITS'(TABLE_DEPTH)) begin
            res_status = ST_FULL;
          end else begin
            res_status = ST_OK;
            res_ins    = 1'b1;
            res_pos    = count[IDX_BITS-1:0];
            res_value  = (r_func == FUNC_GET) ? '0 : r_value;
            res_used   = count + CNT_BITS'(1);
            fin_we     = 1'b1;
            fin_addr   = count[IDX_BITS-1:0];
            fin_value  = res_value;
          end
        end
      end
      FUNC_READ_POS: begin
        if (CNT_BITS'(r_pos) < count) begin
          res_status = ST_OK;
          res_found  = 1'b1;
          res_key    = key_rd;
          res_value  = val_rd;
          res_pos    = r_pos;
        end
      end
      default: begin
        res_status = ST_NOTFOUND;
      end
    endcase
  end

  always_comb begin
    if (cmd.shift) begin
      we = pend;
      wa = pend_idx;
      wk = key_rd;
      wv = val_rd;
    end else begin
      we = cmd.load && fin_we;
      wa = fin_addr;
      wk = fin_key;
      wv = fin_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      hit_reg   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        r_func  <= func;
        r_key   <= req_key;
        r_value <= req_value;
        r_pos   <= position;
        idx     <= '0;
        pend    <= 1'b0;
        hit_reg <= 1'b0;
      end
      if (cmd.scan) begin
        if (hit) begin
          hit_reg <= 1'b1;
          hit_idx <= pend_idx;
          hit_val <= val_rd;
          idx     <= CNT_BITS'(pend_idx);
          pend    <= 1'b0;
        end else if (idx < count) begin
          pend     <= 1'b1;
          pend_idx <= idx[IDX_BITS-1:0];
          idx      <= idx_inc;
        end else begin
          pend <= 1'b0;
        end
      end
      if (cmd.shift) begin
        if (idx_inc < count) begin
          pend     <= 1'b1;
          pend_idx <= idx[IDX_BITS-1:0];
          idx      <= idx_inc;
        end else begin
          pend <= 1'b0;
        end
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
        count     <= res_used;
        o_status  <= res_status;
        o_found   <= res_found;
        o_ins     <= res_ins;
        o_key     <= res_key;
        o_value   <= res_value;
        o_pos     <= res_pos;
        o_used    <= res_used;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = o_status;
  assign rsp.found          = o_found;
  assign rsp.inserted       = o_ins;
  assign rsp.out_key        = o_key;
  assign rsp.out_value      = o_value;
  assign rsp.entry_position = o_pos;
  assign rsp.entries_used   = o_used;

endmodule
